@@ rtl/rcst_pkg.sv @@
// Package with the shared types, codes and helpers of the color slot table.
`default_nettype none
package rcst_pkg;

  localparam int SLOTS_PER_POOL_DEF = 64;
  localparam int MAX_POOLS_DEF      = 8;
  localparam int BYTES_PER_SLOT     = 4;
  localparam int CFG_AW             = 3;

  // Register index of the space limit.
  localparam logic CFG_SPACE_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_REUSED   = 3'd1,
    ST_NEW_POOL = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_RELEASED = 3'd4,
    ST_REL_ERR  = 3'd5,
    ST_IMAGE    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_BAD     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_INC  = 2'd0,
    ACT_SET  = 2'd1,
    ACT_NEWP = 2'd2,
    ACT_DEC  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_UPD,
    FSM_FIN,
    FSM_RESP
  } fsm_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] color;
    logic [8:0]  release_slot;
    logic [31:0] reserve_bytes;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  slot_number;
    logic [31:0] byte_offset;
    logic [15:0] ref_count;
    logic        pixel_write;
    logic [31:0] pixel_word;
  } out_word_t;

  typedef struct packed {
    logic [31:0] color;
    logic        valid;
    logic [15:0] refs;
  } slot_t;

  // Swap the red and blue bytes of a color.
  function automatic logic [31:0] swap_rb(input logic [31:0] c);
    swap_rb = {c[31:24], c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/rcst_if.sv @@
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface rcst_in_if;
  logic               valid;
  logic               ready;
  rcst_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcst_out_if;
  logic                valid;
  logic                ready;
  rcst_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rcst_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rcst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/rcst_cell.sv @@
// One slot cell of the rotating slot ring.
`default_nettype none
module rcst_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           shift,
  input  wire rcst_pkg::slot_t d,
  output rcst_pkg::slot_t     q
);
  rcst_pkg::slot_t slot_r;
  rcst_pkg::slot_t slot_nxt;

  // Take the neighbor's slot when the ring rotates.
  always_comb begin
    slot_nxt = slot_r;
    if (shift) begin
      slot_nxt = d;
    end
  end

  // The color is payload; valid and count are cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
      slot_r.refs  <= '0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
      slot_r.refs  <= slot_nxt.refs;
    end
    slot_r.color <= slot_nxt.color;
  end

  assign q = slot_r;
endmodule
`default_nettype wire

@@ rtl/refcounted_color_slot_table.sv @@
// Top level of the reference-counted color slot table.
`default_nettype none
// The slots live in a ring of cells that rotates one slot per cycle during a
// search or update pass, past a single head stage, where compare and update
// happen. An acquire takes one full rotation to search and a second rotation
// to write the chosen slot; an acquire that finds no space answers after the
// search rotation alone. A release takes one rotation, or none when its pool
// is not open. An image reserve or an unknown mode answers without a rotation.
// Pool base offsets sit in a small RAM. The result sits in an output register,
// so a new request is taken while an old result waits.
module refcounted_color_slot_table #(
  parameter int SLOTS_PER_POOL = rcst_pkg::SLOTS_PER_POOL_DEF,
  parameter int MAX_POOLS      = rcst_pkg::MAX_POOLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rcst_in_if.sink                          in_ch,
  rcst_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [rcst_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);
  localparam int TOTAL = SLOTS_PER_POOL * MAX_POOLS;
  localparam int LW    = $clog2(TOTAL);
  localparam int IW    = $clog2(SLOTS_PER_POOL);
  localparam int PW    = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int POW   = $clog2(MAX_POOLS + 1);
  localparam logic [31:0] POOL_BYTES = 32'(SLOTS_PER_POOL * rcst_pkg::BYTES_PER_SLOT);

  // Configuration register.
  logic [31:0] space_limit_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_limit_r <= '1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == rcst_pkg::CFG_SPACE_LIMIT) begin
      space_limit_r <= cfg_pwdata;
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == rcst_pkg::CFG_SPACE_LIMIT) ? space_limit_r : 32'd0;

  // Slot ring: cell 0 is the head, the last cell takes the written-back head.
  rcst_pkg::slot_t cell_q [TOTAL];
  rcst_pkg::slot_t head;
  rcst_pkg::slot_t wb;
  logic            shift;

  for (genvar k = 0; k < TOTAL; k++) begin : g_cell
    rcst_pkg::slot_t d_k;
    if (k == TOTAL - 1) begin : g_last
      assign d_k = wb;
    end else begin : g_mid
      assign d_k = cell_q[k+1];
    end
    rcst_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d     (d_k),
      .q     (cell_q[k])
    );
  end
  assign head = cell_q[0];

  // Control registers.
  rcst_pkg::fsm_t  state_r, state_nxt;
  rcst_pkg::act_t  act_r, act_nxt;
  logic [LW-1:0]   lin_r, lin_nxt;
  logic [IW-1:0]   ic_r, ic_nxt;
  logic [PW-1:0]   pc_r, pc_nxt;
  logic [POW-1:0]  pools_open_r, pools_open_nxt;
  logic [31:0]     alloc_r, alloc_nxt;
  logic            hit_r, hit_nxt, emp_r, emp_nxt;
  logic [PW-1:0]   hit_pool_r, hit_pool_nxt, emp_pool_r, emp_pool_nxt;
  logic [LW-1:0]   hit_lin_r, hit_lin_nxt, emp_lin_r, emp_lin_nxt;
  logic [LW-1:0]   tgt_lin_r, tgt_lin_nxt;
  logic            out_v_r, out_v_nxt;

  // Payload registers.
  logic [31:0]     color_r, color_nxt;
  logic [8:0]      rel_r, rel_nxt;
  logic [2:0]      st_r, st_nxt;
  logic [8:0]      slot_r, slot_nxt;
  logic [15:0]     rc_r, rc_nxt;
  logic            pw_r, pw_nxt;
  logic [31:0]     off_r, off_nxt;
  logic            use_base_r, use_base_nxt;
  logic [PW-1:0]   cap_pool_r, cap_pool_nxt;
  logic [IW-1:0]   cap_idx_r, cap_idx_nxt;
  logic [PW-1:0]   new_pool_r, new_pool_nxt;
  rcst_pkg::out_word_t out_d_r, out_d_nxt;

  // Pool base RAM.
  logic            pb_we;
  logic [31:0]     pb_rdata;
  rcst_ram #(.WIDTH(32), .DEPTH(MAX_POOLS)) u_pool_base (
    .clk   (clk),
    .we    (pb_we),
    .waddr (PW'(pools_open_r)),
    .wdata (alloc_r),
    .raddr (cap_pool_r),
    .rdata (pb_rdata)
  );

  logic        head_open, match, empty_s, last;
  logic [32:0] adv;
  logic        adv_ok;
  logic        in_take, out_load;
  logic [31:0] in_mode_bytes;
  logic [15:0] refs_inc;

  assign head_open = POW'(pc_r) < pools_open_r;
  assign match     = head_open && head.valid && head.color == color_r;
  assign empty_s   = head_open && head.refs == 16'd0;
  assign last      = lin_r == LW'(TOTAL - 1);
  assign refs_inc  = (head.refs == 16'hFFFF) ? head.refs : head.refs + 16'd1;

  // Bump pointer check, for a new pool or an image region.
  assign in_mode_bytes = (state_r == rcst_pkg::FSM_IDLE) ?
                         in_ch.data.reserve_bytes : POOL_BYTES;
  assign adv    = {1'b0, alloc_r} + {1'b0, in_mode_bytes};
  assign adv_ok = !adv[32] && adv[31:0] <= space_limit_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcst_pkg::FSM_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.mode == rcst_pkg::MODE_ACQUIRE) begin
            state_nxt = rcst_pkg::FSM_SCAN;
          end else if (in_ch.data.mode == rcst_pkg::MODE_RELEASE &&
                       32'(in_ch.data.release_slot) <
                       32'(pools_open_r) * SLOTS_PER_POOL) begin
            state_nxt = rcst_pkg::FSM_UPD;
          end else begin
            state_nxt = rcst_pkg::FSM_RESP;
          end
        end
      end
      rcst_pkg::FSM_SCAN: begin
        if (last) begin
          if (hit_nxt || emp_nxt ||
              (pools_open_r < POW'(MAX_POOLS) && adv_ok)) begin
            state_nxt = rcst_pkg::FSM_UPD;
          end else begin
            state_nxt = rcst_pkg::FSM_RESP;
          end
        end
      end
      rcst_pkg::FSM_UPD: begin
        if (last) begin
          state_nxt = rcst_pkg::FSM_FIN;
        end
      end
      rcst_pkg::FSM_FIN:  state_nxt = rcst_pkg::FSM_RESP;
      rcst_pkg::FSM_RESP: begin
        if (!out_v_r || out_ch.ready) begin
          state_nxt = rcst_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = rcst_pkg::FSM_IDLE;
    endcase
  end

  // Handshake and ring strobes.
  always_comb begin
    in_ch.ready = 1'b0;
    shift       = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      rcst_pkg::FSM_IDLE: in_ch.ready = 1'b1;
      rcst_pkg::FSM_SCAN: shift = 1'b1;
      rcst_pkg::FSM_UPD:  shift = 1'b1;
      rcst_pkg::FSM_RESP: out_load = !out_v_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end
  assign in_take = in_ch.valid && in_ch.ready;

  // Datapath: intake, scan bookkeeping, decision and head update.
  always_comb begin
    act_nxt        = act_r;
    lin_nxt        = lin_r;
    ic_nxt         = ic_r;
    pc_nxt         = pc_r;
    pools_open_nxt = pools_open_r;
    alloc_nxt      = alloc_r;
    hit_nxt        = hit_r;
    hit_pool_nxt   = hit_pool_r;
    hit_lin_nxt    = hit_lin_r;
    emp_nxt        = emp_r;
    emp_pool_nxt   = emp_pool_r;
    emp_lin_nxt    = emp_lin_r;
    tgt_lin_nxt    = tgt_lin_r;
    color_nxt      = color_r;
    rel_nxt        = rel_r;
    st_nxt         = st_r;
    slot_nxt       = slot_r;
    rc_nxt         = rc_r;
    pw_nxt         = pw_r;
    off_nxt        = off_r;
    use_base_nxt   = use_base_r;
    cap_pool_nxt   = cap_pool_r;
    cap_idx_nxt    = cap_idx_r;
    new_pool_nxt   = new_pool_r;
    pb_we          = 1'b0;
    wb             = head;

    // Position counters follow the head while the ring turns.
    if (shift) begin
      if (last) begin
        lin_nxt = '0;
        ic_nxt  = '0;
        pc_nxt  = '0;
      end else begin
        lin_nxt = lin_r + LW'(1);
        if (ic_r == IW'(SLOTS_PER_POOL - 1)) begin
          ic_nxt = '0;
          pc_nxt = pc_r + PW'(1);
        end else begin
          ic_nxt = ic_r + IW'(1);
        end
      end
    end

    // Accept a request.
    if (in_take) begin
      color_nxt    = in_ch.data.color;
      rel_nxt      = in_ch.data.release_slot;
      hit_nxt      = 1'b0;
      emp_nxt      = 1'b0;
      use_base_nxt = 1'b0;
      slot_nxt     = '0;
      off_nxt      = '0;
      rc_nxt       = '0;
      pw_nxt       = 1'b0;
      st_nxt       = rcst_pkg::ST_REL_ERR;
      case (in_ch.data.mode)
        rcst_pkg::MODE_RELEASE: begin
          act_nxt     = rcst_pkg::ACT_DEC;
          tgt_lin_nxt = LW'(in_ch.data.release_slot);
          slot_nxt    = in_ch.data.release_slot;
        end
        rcst_pkg::MODE_RESERVE: begin
          if (adv_ok) begin
            st_nxt    = rcst_pkg::ST_IMAGE;
            off_nxt   = alloc_r;
            alloc_nxt = adv[31:0];
          end else begin
            st_nxt = rcst_pkg::ST_NO_SPACE;
          end
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end

    // Search: newest pool wins a hit, then lowest index; the oldest pool
    // and its highest index win an unused slot.
    if (state_r == rcst_pkg::FSM_SCAN) begin
      if (match && (!hit_r || pc_r != hit_pool_r)) begin
        hit_nxt      = 1'b1;
        hit_pool_nxt = pc_r;
        hit_lin_nxt  = lin_r;
      end
      if (empty_s && (!emp_r || pc_r == emp_pool_r)) begin
        emp_nxt      = 1'b1;
        emp_pool_nxt = pc_r;
        emp_lin_nxt  = lin_r;
      end
      if (last) begin
        if (hit_nxt) begin
          act_nxt     = rcst_pkg::ACT_INC;
          tgt_lin_nxt = hit_lin_nxt;
        end else if (emp_nxt) begin
          act_nxt     = rcst_pkg::ACT_SET;
          tgt_lin_nxt = emp_lin_nxt;
        end else if (pools_open_r < POW'(MAX_POOLS) && adv_ok) begin
          act_nxt        = rcst_pkg::ACT_NEWP;
          tgt_lin_nxt    = LW'(32'(pools_open_r) * SLOTS_PER_POOL);
          new_pool_nxt   = PW'(pools_open_r);
          off_nxt        = alloc_r;
          alloc_nxt      = adv[31:0];
          pools_open_nxt = pools_open_r + POW'(1);
          pb_we          = 1'b1;
        end else begin
          st_nxt = rcst_pkg::ST_NO_SPACE;
        end
      end
    end

    // Update pass: clear a newly opened pool and write the target slot as it passes the head.
    if (state_r == rcst_pkg::FSM_UPD) begin
      if (act_r == rcst_pkg::ACT_NEWP && pc_r == new_pool_r) begin
        wb.valid = 1'b0;
        wb.refs  = '0;
      end
      if (lin_r == tgt_lin_r) begin
        cap_pool_nxt = pc_r;
        cap_idx_nxt  = ic_r;
        slot_nxt     = 9'(lin_r);
        case (act_r)
          rcst_pkg::ACT_INC: begin
            wb.refs      = refs_inc;
            st_nxt       = rcst_pkg::ST_HIT;
            rc_nxt       = refs_inc;
            use_base_nxt = 1'b1;
          end
          rcst_pkg::ACT_SET, rcst_pkg::ACT_NEWP: begin
            wb.color     = color_r;
            wb.valid     = 1'b1;
            wb.refs      = 16'd1;
            rc_nxt       = 16'd1;
            pw_nxt       = 1'b1;
            st_nxt       = (act_r == rcst_pkg::ACT_SET) ? rcst_pkg::ST_REUSED :
                           rcst_pkg::ST_NEW_POOL;
            use_base_nxt = act_r == rcst_pkg::ACT_SET;
          end
          default: begin
            if (head.refs != 16'd0) begin
              wb.refs      = head.refs - 16'd1;
              rc_nxt       = head.refs - 16'd1;
              st_nxt       = rcst_pkg::ST_RELEASED;
              use_base_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Output register.
  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    if (out_load) begin
      out_v_nxt             = 1'b1;
      out_d_nxt.status      = st_r;
      out_d_nxt.slot_number = slot_r;
      out_d_nxt.byte_offset = use_base_r ?
                              pb_rdata + 32'({cap_idx_r, 2'b00}) : off_r;
      out_d_nxt.ref_count   = rc_r;
      out_d_nxt.pixel_write = pw_r;
      out_d_nxt.pixel_word  = pw_r ? rcst_pkg::swap_rb(color_r) : 32'd0;
    end
  end
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rcst_pkg::FSM_IDLE;
      lin_r        <= '0;
      ic_r         <= '0;
      pc_r         <= '0;
      pools_open_r <= '0;
      alloc_r      <= '0;
      hit_r        <= 1'b0;
      emp_r        <= 1'b0;
      out_v_r      <= 1'b0;
      act_r        <= rcst_pkg::ACT_INC;
    end else begin
      state_r      <= state_nxt;
      lin_r        <= lin_nxt;
      ic_r         <= ic_nxt;
      pc_r         <= pc_nxt;
      pools_open_r <= pools_open_nxt;
      alloc_r      <= alloc_nxt;
      hit_r        <= hit_nxt;
      emp_r        <= emp_nxt;
      out_v_r      <= out_v_nxt;
      act_r        <= act_nxt;
    end
    hit_pool_r <= hit_pool_nxt;
    hit_lin_r  <= hit_lin_nxt;
    emp_pool_r <= emp_pool_nxt;
    emp_lin_r  <= emp_lin_nxt;
    tgt_lin_r  <= tgt_lin_nxt;
    color_r    <= color_nxt;
    rel_r      <= rel_nxt;
    st_r       <= st_nxt;
    slot_r     <= slot_nxt;
    rc_r       <= rc_nxt;
    pw_r       <= pw_nxt;
    off_r      <= off_nxt;
    use_base_r <= use_base_nxt;
    cap_pool_r <= cap_pool_nxt;
    cap_idx_r  <= cap_idx_nxt;
    new_pool_r <= new_pool_nxt;
    out_d_r    <= out_d_nxt;
  end

  // The pool count never passes the pool limit.
  a_pools_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pools_open_r <= POW'(MAX_POOLS))
    else $error("pool count above limit");

  // A pass always starts with the head at slot zero.
  a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rcst_pkg::FSM_IDLE && in_take) |=> lin_r == '0 && pc_r == '0)
    else $error("ring position not at slot zero");

  // A hit never asks for a pixel store.
  a_hit_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.status == rcst_pkg::ST_HIT) |-> !out_d_r.pixel_write)
    else $error("pixel store on a hit");

  // Leaving the update pass, the ring is back in its home position.
  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rcst_pkg::FSM_FIN) |-> lin_r == '0 && $past(last))
    else $error("update pass ended off position");

  // rel_r keeps the release slot so that the echoed slot number of a release can be checked.
  a_rel_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rcst_pkg::FSM_UPD && act_r == rcst_pkg::ACT_DEC) |->
      slot_r == rel_r)
    else $error("release slot echo lost");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the reference-counted colour slot table.
`timescale 1ns / 1ps
module tb_top;
  import rcst_pkg::*;

  localparam int POOL_SLOTS = 64;
  localparam int POOL_COUNT = 8;
  localparam int SLOT_TOTAL = POOL_SLOTS * POOL_COUNT;
  localparam int POOL_BYTES = POOL_SLOTS * 4;
  localparam int SETTLE_CYCLES = 1200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_CYCLES = 3000;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  rcst_in_if in_if ();
  rcst_out_if out_if ();

  refcounted_color_slot_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Requests waiting to be driven and results the table must still return.
  in_word_t req_q[$];
  out_word_t result_q[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int status_seen[8];

  // Shadow copy of the table state.
  logic [31:0] tbl_color[SLOT_TOTAL];
  bit tbl_valid[SLOT_TOTAL];
  logic [15:0] tbl_refs[SLOT_TOTAL];
  logic [31:0] tbl_base[POOL_COUNT];
  int tbl_pools;
  logic [31:0] tbl_ptr;
  logic [31:0] tbl_limit;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stored pixel order puts blue in the low byte.
  function automatic logic [31:0] pixel_of(logic [31:0] c);
    return {c[31:24], c[7:0], c[15:8], c[23:16]};
  endfunction

  // Bump the allocation pointer if the region fits under the limit.
  function automatic bit claim_space(logic [31:0] bytes, output logic [31:0] start);
    logic [32:0] np;
    np = {1'b0, tbl_ptr} + {1'b0, bytes};
    start = '0;
    if (np[32] || np[31:0] > tbl_limit) return 1'b0;
    start = tbl_ptr;
    tbl_ptr = np[31:0];
    return 1'b1;
  endfunction

  // Compute the result of one request and update the shadow state.
  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    int p, i, s, ep, ei;
    bit have_free;
    logic [31:0] start;
    r = '0;
    case (w.mode)
      MODE_ACQUIRE: begin
        have_free = 1'b0;
        ep = 0;
        ei = 0;
        // Newest pool first; the last unused slot seen wins.
        for (p = tbl_pools - 1; p >= 0; p--) begin
          for (i = 0; i < POOL_SLOTS; i++) begin
            s = p * POOL_SLOTS + i;
            if (tbl_valid[s] && tbl_color[s] == w.color) begin
              if (tbl_refs[s] != 16'hFFFF) tbl_refs[s]++;
              r.status = ST_HIT;
              r.slot_number = 9'(s);
              r.byte_offset = tbl_base[p] + 32'(i * 4);
              r.ref_count = tbl_refs[s];
              return r;
            end
            if (tbl_refs[s] == 0) begin
              have_free = 1'b1;
              ep = p;
              ei = i;
            end
          end
        end
        if (have_free) begin
          s = ep * POOL_SLOTS + ei;
          tbl_refs[s] = 16'd1;
          tbl_color[s] = w.color;
          tbl_valid[s] = 1'b1;
          r.status = ST_REUSED;
          r.slot_number = 9'(s);
          r.byte_offset = tbl_base[ep] + 32'(ei * 4);
          r.ref_count = 16'd1;
          r.pixel_write = 1'b1;
          r.pixel_word = pixel_of(w.color);
        end else if (tbl_pools >= POOL_COUNT || !claim_space(POOL_BYTES, start)) begin
          r.status = ST_NO_SPACE;
        end else begin
          p = tbl_pools;
          tbl_pools++;
          tbl_base[p] = start;
          for (i = 0; i < POOL_SLOTS; i++) begin
            tbl_valid[p * POOL_SLOTS + i] = 1'b0;
            tbl_refs[p * POOL_SLOTS + i] = '0;
          end
          s = p * POOL_SLOTS;
          tbl_refs[s] = 16'd1;
          tbl_color[s] = w.color;
          tbl_valid[s] = 1'b1;
          r.status = ST_NEW_POOL;
          r.slot_number = 9'(s);
          r.byte_offset = start;
          r.ref_count = 16'd1;
          r.pixel_write = 1'b1;
          r.pixel_word = pixel_of(w.color);
        end
      end
      MODE_RELEASE: begin
        p = int'(w.release_slot) / POOL_SLOTS;
        i = int'(w.release_slot) % POOL_SLOTS;
        r.slot_number = w.release_slot;
        if (p >= tbl_pools || tbl_refs[int'(w.release_slot)] == 0) begin
          r.status = ST_REL_ERR;
        end else begin
          s = int'(w.release_slot);
          tbl_refs[s]--;
          r.status = ST_RELEASED;
          r.byte_offset = tbl_base[p] + 32'(i * 4);
          r.ref_count = tbl_refs[s];
        end
      end
      MODE_RESERVE: begin
        if (claim_space(w.reserve_bytes, start)) begin
          r.status = ST_IMAGE;
          r.byte_offset = start;
        end else begin
          r.status = ST_NO_SPACE;
        end
      end
      default: r.status = ST_REL_ERR;
    endcase
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic v;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(predict_result(in_if.data));
        words_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        v = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          in_if.data <= req_q.pop_front();
          v = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
        in_if.valid <= v;
      end
    end
  end

  // Receiver: alternating stretches of full and random readiness, plus one
  // long hold-off that backs the table up.
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    logic r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else if (!hold_done && words_out >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLDOFF_CYCLES;
        r = 1'b0;
      end else if ((rx_cycle / 700) % 2 == 0) begin
        r = 1'b1;
      end else begin
        r = ($urandom_range(0, 2) != 0);
      end
      out_if.ready <= r;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Monitor: each result word against the oldest prediction.
  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      words_out++;
      status_seen[out_if.data.status]++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_if.data);
        errors++;
      end else begin
        w = result_q.pop_front();
        check_field("status", 32'(w.status), 32'(out_if.data.status));
        check_field("slot_number", 32'(w.slot_number), 32'(out_if.data.slot_number));
        check_field("byte_offset", w.byte_offset, out_if.data.byte_offset);
        check_field("ref_count", 32'(w.ref_count), 32'(out_if.data.ref_count));
        check_field("pixel_write", 32'(w.pixel_write), 32'(out_if.data.pixel_write));
        check_field("pixel_word", w.pixel_word, out_if.data.pixel_word);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, result_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(mode_t m, logic [31:0] c, logic [8:0] rel, logic [31:0] bytes);
    in_word_t w;
    w.mode = m;
    w.color = c;
    w.release_slot = rel;
    w.reserve_bytes = bytes;
    req_q.push_back(w);
  endtask

  // Wait until every request is out and every result is back, then settle.
  task automatic drain();
    while (req_q.size() != 0 || result_q.size() != 0 || in_if.valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the space limit.
  task automatic write_limit(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(CFG_SPACE_LIMIT) << 2;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tbl_limit = value;
  endtask

  // Stimulus.
  initial begin
    logic [31:0] palette[8];
    int n, k;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    tbl_pools = 0;
    tbl_ptr = '0;
    tbl_limit = 32'hFFFF_FFFF;
    for (k = 0; k < SLOT_TOTAL; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_refs[k] = '0;
      tbl_color[k] = '0;
    end
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: black never matches an unwritten slot, hits, reuse, a hit on
    // a valid slot whose count went to zero, release errors, the unknown
    // mode, image reserves and pointer overflow.
    write_limit(32'hFFFF_FFFF);
    push_req(MODE_ACQUIRE, 32'h0000_0000, '0, '0);
    push_req(MODE_ACQUIRE, 32'h0000_0000, '0, '0);
    push_req(MODE_ACQUIRE, 32'hFFFF_FFFF, '0, '0);
    push_req(MODE_ACQUIRE, 32'h1122_3344, '0, '0);
    push_req(MODE_RELEASE, '0, 9'd0, '0);
    push_req(MODE_RELEASE, '0, 9'd0, '0);
    push_req(MODE_RELEASE, '0, 9'd0, '0);
    push_req(MODE_ACQUIRE, 32'h0000_0000, '0, '0);
    push_req(MODE_RELEASE, '0, 9'd511, '0);
    push_req(MODE_RELEASE, '0, 9'd5, '0);
    push_req(MODE_BAD, $urandom(), 9'($urandom()), $urandom());
    push_req(MODE_RESERVE, '0, '0, 32'd0);
    push_req(MODE_RESERVE, '0, '0, 32'd100);
    push_req(MODE_ACQUIRE, 32'h8000_00FF, '0, '0);
    push_req(MODE_RESERVE, '0, '0, 32'hFFFF_FFFF);
    push_req(MODE_RELEASE, '0, 9'd2, '0);
    push_req(MODE_ACQUIRE, 32'h00FF_FF00, '0, '0);
    drain();

    // Zero limit: every claim on space fails.
    write_limit(32'h0000_0000);
    push_req(MODE_RESERVE, '0, '0, 32'd0);
    push_req(MODE_RESERVE, '0, '0, 32'd1);
    push_req(MODE_ACQUIRE, 32'hA5A5_5A5A, '0, '0);
    drain();
    write_limit(32'hFFFF_FFFF);

    // Random traffic over a small palette so hits and releases are common.
    palette[0] = 32'h0000_0000;
    palette[1] = 32'hFFFF_FFFF;
    for (k = 2; k < 8; k++) palette[k] = $urandom();
    for (n = 0; n < 300; n++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        push_req(MODE_ACQUIRE, ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 7)]
                 : $urandom(), 9'($urandom()), $urandom());
      end else if (k < 82) begin
        k = $urandom_range(0, 99);
        push_req(MODE_RELEASE, $urandom(), (k < 60) ? 9'($urandom_range(0, 15)) :
                 (k < 85) ? 9'($urandom_range(0, 127)) : 9'($urandom_range(0, 511)),
                 $urandom());
      end else if (k < 95) begin
        push_req(MODE_RESERVE, $urandom(), 9'($urandom()),
                 ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4096));
      end else begin
        push_req(MODE_BAD, $urandom(), 9'($urandom()), $urandom());
      end
    end
    drain();

    // Room for a few more pools only, then fill with distinct colors.
    write_limit(tbl_ptr + 32'(3 * POOL_BYTES + 10));
    for (n = 0; n < 260; n++) begin
      if ($urandom_range(0, 19) == 0)
        push_req(MODE_RESERVE, $urandom(), 9'($urandom()), $urandom_range(0, 64));
      else
        push_req(MODE_ACQUIRE, $urandom(), 9'($urandom()), $urandom());
    end
    drain();

    // Full space: open pools until the pool count runs out, with releases mixed in.
    write_limit(32'hFFFF_FFFF);
    for (n = 0; n < 280; n++) begin
      if ($urandom_range(0, 9) == 0)
        push_req(MODE_RELEASE, $urandom(), 9'($urandom_range(0, 511)), $urandom());
      else
        push_req(MODE_ACQUIRE, $urandom(), 9'($urandom()), $urandom());
    end
    drain();

    $display("Sent %0d requests, checked %0d results: hit %0d, reused %0d, new pool %0d,",
             words_in, words_out, status_seen[ST_HIT], status_seen[ST_REUSED],
             status_seen[ST_NEW_POOL]);
    $display("no space %0d, released %0d, release error %0d, image %0d; pools open %0d.",
             status_seen[ST_NO_SPACE], status_seen[ST_RELEASED], status_seen[ST_REL_ERR],
             status_seen[ST_IMAGE], tbl_pools);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
